>>> rtl/core/assert_macros.svh
// ---------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion wrappers for the core RTL.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef ASSERT_OFF
`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("assertion failed: same-cycle implication");
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("assertion failed: next-cycle implication");
`else
`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons)
`define ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif

`endif

>>> rtl/core/sfwr_pkg.sv
// ---------------------------------------------------------------------------
// Searchable FIFO package
// Shared constants, command codes and cell control type.
// ---------------------------------------------------------------------------
package sfwr_pkg;

    localparam int QUEUE_DEPTH_DEF = 16;
    localparam int TAG_BITS_DEF    = 32;
    localparam int STAMP_BITS_DEF  = 48;

    localparam int CAP_W = 5;
    localparam logic [CAP_W-1:0] CAP_RESET = 5'd16;

    localparam logic [2:0] CMD_PUSH   = 3'd0;
    localparam logic [2:0] CMD_POP    = 3'd1;
    localparam logic [2:0] CMD_SEARCH = 3'd2;
    localparam logic [2:0] CMD_REMOVE = 3'd3;
    localparam logic [2:0] CMD_READ   = 3'd4;

    typedef struct packed {
        logic load;
        logic shift;
    } t_cell_ctrl;

endpackage

>>> rtl/core/sfwr_cell.sv
// ---------------------------------------------------------------------------
// Searchable FIFO cell
// Holds one entry, loads a pushed item or takes its neighbor's entry, and
// compares its tag with the search tag.
// ---------------------------------------------------------------------------
module sfwr_cell
    import sfwr_pkg::*;
#(
    parameter int TAG_BITS   = TAG_BITS_DEF,
    parameter int STAMP_BITS = STAMP_BITS_DEF
) (
    input  logic                  i_clk,
    input  t_cell_ctrl            i_ctrl,
    input  logic [TAG_BITS-1:0]   i_push_tag,
    input  logic [STAMP_BITS-1:0] i_push_stamp,
    input  logic [TAG_BITS-1:0]   i_next_tag,
    input  logic [STAMP_BITS-1:0] i_next_stamp,
    input  logic [TAG_BITS-1:0]   i_search_tag,
    output logic [TAG_BITS-1:0]   o_tag,
    output logic [STAMP_BITS-1:0] o_stamp,
    output logic                  o_match
);

    logic [TAG_BITS-1:0]   r_tag;
    logic [STAMP_BITS-1:0] r_stamp;

    always_ff @(posedge i_clk) begin
        if (i_ctrl.load) begin
            r_tag   <= i_push_tag;
            r_stamp <= i_push_stamp;
        end else if (i_ctrl.shift) begin
            r_tag   <= i_next_tag;
            r_stamp <= i_next_stamp;
        end
    end

    assign o_tag   = r_tag;
    assign o_stamp = r_stamp;
    assign o_match = (r_tag == i_search_tag);

endmodule

>>> rtl/core/searchable_fifo_with_removal_core.sv
// ---------------------------------------------------------------------------
// Searchable FIFO with removal, core
// Ordered queue built as a chain of cells with push, pop, search, remove at
// position and stamp read; one command per cycle.
// ---------------------------------------------------------------------------
// The result strobe is registered and rises in the cycle after start is taken.
// Throughput: one item per cycle; busy stays low, since every cell of the
// chain compares combinationally and loads or shifts at the same clock edge.
// Reset (synchronous, active low) empties the queue, sets the capacity to
// 16 and clears the strobe; the receiver cannot stall results.
module searchable_fifo_with_removal_core
    import sfwr_pkg::*;
#(
    parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF,
    parameter int TAG_BITS    = TAG_BITS_DEF,
    parameter int STAMP_BITS  = STAMP_BITS_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  start,
    output logic                  busy,
    input  logic [2:0]            i_command,
    input  logic [TAG_BITS-1:0]   i_owner_tag,
    input  logic [STAMP_BITS-1:0] i_arrival_stamp,
    input  logic [3:0]            i_position,
    input  logic                  i_cfg_we,
    input  logic [CAP_W-1:0]      i_cfg_wdata,
    output logic                  o_valid,
    output logic                  o_done_ok,
    output logic [TAG_BITS-1:0]   o_tag_out,
    output logic [STAMP_BITS-1:0] o_stamp_out,
    output logic [3:0]            o_found_position,
    output logic [4:0]            o_entry_count,
    output logic                  o_is_empty,
    output logic                  o_is_full,
    output logic [STAMP_BITS-1:0] o_head_stamp
);

    `include "assert_macros.svh"

    localparam int COUNT_W = $clog2(QUEUE_DEPTH + 1);
    localparam int CMP_W   = (COUNT_W > CAP_W) ? COUNT_W : CAP_W;
    localparam logic [CMP_W-1:0] DEPTH_C = CMP_W'(QUEUE_DEPTH);

    logic [COUNT_W-1:0]    r_count, n_count;
    logic [CAP_W-1:0]      r_cap;
    logic                  r_valid;
    logic                  r_done_ok, n_done_ok;
    logic [TAG_BITS-1:0]   r_tag_out, n_tag_out;
    logic [STAMP_BITS-1:0] r_stamp_out, n_stamp_out;
    logic [3:0]            r_found, n_found;

    logic [TAG_BITS-1:0]   w_tag   [QUEUE_DEPTH];
    logic [STAMP_BITS-1:0] w_stamp [QUEUE_DEPTH];
    logic [QUEUE_DEPTH-1:0] w_match;
    t_cell_ctrl            w_ctrl  [QUEUE_DEPTH];

    logic                  w_accept;
    logic [CMP_W-1:0]      w_count;
    logic [CMP_W-1:0]      w_cap_eff;
    logic [CMP_W-1:0]      w_pos;
    logic [CMP_W-1:0]      w_rm_pos;
    logic                  w_push_ok;
    logic                  w_remove_ok;
    logic                  w_pos_ok;
    logic                  w_hit;
    logic [CMP_W-1:0]      w_hit_idx;
    logic [TAG_BITS-1:0]   w_sel_tag;
    logic [STAMP_BITS-1:0] w_sel_stamp;

    assign busy     = 1'b0;
    assign w_accept = start && !busy;
    assign w_count  = CMP_W'(r_count);
    assign w_pos    = CMP_W'(i_position);

    always_comb begin
        if (r_cap == '0) begin
            w_cap_eff = CMP_W'(1);
        end else if (CMP_W'(r_cap) > DEPTH_C) begin
            w_cap_eff = DEPTH_C;
        end else begin
            w_cap_eff = CMP_W'(r_cap);
        end
    end

    assign w_pos_ok  = (w_pos < w_count);
    assign w_push_ok = w_accept && (i_command == CMD_PUSH)
                       && (w_count < w_cap_eff) && (w_count < DEPTH_C);
    assign w_remove_ok = w_accept
                         && (((i_command == CMD_POP) && (w_count != '0))
                             || ((i_command == CMD_REMOVE) && w_pos_ok));
    assign w_rm_pos  = (i_command == CMD_POP) ? '0 : w_pos;

    always_comb begin
        w_hit     = 1'b0;
        w_hit_idx = '0;
        w_sel_tag   = '0;
        w_sel_stamp = '0;
        for (int i = QUEUE_DEPTH - 1; i >= 0; i--) begin
            if (w_match[i] && (CMP_W'(i) < w_count)) begin
                w_hit     = 1'b1;
                w_hit_idx = CMP_W'(i);
            end
        end
        for (int i = 0; i < QUEUE_DEPTH; i++) begin
            if (w_rm_pos == CMP_W'(i)) begin
                w_sel_tag   = w_tag[i];
                w_sel_stamp = w_stamp[i];
            end
        end
    end

    genvar g;
    generate
        for (g = 0; g < QUEUE_DEPTH; g++) begin : g_cell
            logic [TAG_BITS-1:0]   w_next_tag;
            logic [STAMP_BITS-1:0] w_next_stamp;

            if (g == QUEUE_DEPTH - 1) begin : g_last
                assign w_next_tag   = w_tag[g];
                assign w_next_stamp = w_stamp[g];
            end else begin : g_mid
                assign w_next_tag   = w_tag[g+1];
                assign w_next_stamp = w_stamp[g+1];
            end

            assign w_ctrl[g].load  = w_push_ok && (w_count == CMP_W'(g));
            assign w_ctrl[g].shift = w_remove_ok && (CMP_W'(g) >= w_rm_pos);

            sfwr_cell #(
                .TAG_BITS  (TAG_BITS),
                .STAMP_BITS(STAMP_BITS)
            ) u_cell (
                .i_clk       (i_clk),
                .i_ctrl      (w_ctrl[g]),
                .i_push_tag  (i_owner_tag),
                .i_push_stamp(i_arrival_stamp),
                .i_next_tag  (w_next_tag),
                .i_next_stamp(w_next_stamp),
                .i_search_tag(i_owner_tag),
                .o_tag       (w_tag[g]),
                .o_stamp     (w_stamp[g]),
                .o_match     (w_match[g])
            );
        end
    endgenerate

    always_comb begin
        n_count     = r_count;
        n_done_ok   = 1'b0;
        n_tag_out   = '0;
        n_stamp_out = '0;
        n_found     = '0;
        unique case (i_command) inside
            CMD_PUSH: begin
                if (w_push_ok) begin
                    n_count   = r_count + COUNT_W'(1);
                    n_done_ok = 1'b1;
                end
            end
            CMD_POP, CMD_REMOVE: begin
                if (w_remove_ok) begin
                    n_count     = r_count - COUNT_W'(1);
                    n_done_ok   = 1'b1;
                    n_tag_out   = w_sel_tag;
                    n_stamp_out = w_sel_stamp;
                end
            end
            CMD_SEARCH: begin
                if (w_hit) begin
                    n_done_ok = 1'b1;
                    n_found   = w_hit_idx[3:0];
                end
            end
            CMD_READ: begin
                if (w_pos_ok) begin
                    n_done_ok   = 1'b1;
                    n_stamp_out = w_sel_stamp;
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
            r_cap   <= CAP_RESET;
            r_valid <= 1'b0;
        end else begin
            if (w_accept) begin
                r_count <= n_count;
            end
            if (i_cfg_we) begin
                r_cap <= i_cfg_wdata;
            end
            r_valid <= w_accept;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_done_ok   <= n_done_ok;
            r_tag_out   <= n_tag_out;
            r_stamp_out <= n_stamp_out;
            r_found     <= n_found;
        end
    end

    assign o_valid          = r_valid;
    assign o_done_ok        = r_done_ok;
    assign o_tag_out        = r_tag_out;
    assign o_stamp_out      = r_stamp_out;
    assign o_found_position = r_found;
    assign o_entry_count    = 5'(r_count);
    assign o_is_empty       = (r_count == '0);
    assign o_is_full        = (w_count >= w_cap_eff);
    assign o_head_stamp     = (r_count == '0) ? '0 : w_stamp[0];

    `ASSERT_IMPLIES(a_count_range, i_clk, i_rst_n, 1'b1, w_count <= DEPTH_C)
    `ASSERT_NEXT(a_push_grows, i_clk, i_rst_n, w_push_ok, r_count == $past(r_count) + COUNT_W'(1))
    `ASSERT_NEXT(a_remove_shrinks, i_clk, i_rst_n, w_remove_ok, r_count == $past(r_count) - COUNT_W'(1))
    `ASSERT_IMPLIES(a_fail_no_change, i_clk, i_rst_n, r_valid && !r_done_ok, r_count == $past(r_count))

endmodule

>>> tb/sv/tb.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Searchable FIFO with removal, testbench
// Drives push, pop, search, remove and stamp read commands through the core
// under several capacity settings, with random idle bursts. A shadow queue
// inside a small scoreboard predicts every result, and each result is
// checked field by field against the oldest prediction.
// ---------------------------------------------------------------------------
module tb;
    import sfwr_pkg::*;

    localparam int DEPTH = QUEUE_DEPTH_DEF;
    localparam int TAG_W = TAG_BITS_DEF;
    localparam int STAMP_W = STAMP_BITS_DEF;
    localparam logic [2:0] CMD_SPARE_FIRST = 3'd5;
    localparam logic [2:0] CMD_SPARE_LAST = 3'd7;
    localparam int STALL_LIMIT = 1000;
    localparam int PHASES = 13;
    localparam int PHASE_ITEMS = 100;

    typedef struct packed {
        logic               ok;
        logic [TAG_W-1:0]   tag;
        logic [STAMP_W-1:0] stamp;
        logic [3:0]         found;
        logic [4:0]         count;
        logic               empty;
        logic               full;
        logic [STAMP_W-1:0] head;
    } t_queue_result;

    class fifo_scoreboard;
        logic [TAG_W-1:0]   tags[DEPTH];
        logic [STAMP_W-1:0] stamps[DEPTH];
        int                 held;
        logic [CAP_W-1:0]   cap_reg;
        t_queue_result      awaited[$];
        int                 errors;

        function new();
            held = 0;
            cap_reg = CAP_RESET;
            errors = 0;
        endfunction

        function int capacity();
            if (cap_reg == 0) return 1;
            if (cap_reg > DEPTH) return DEPTH;
            return int'(cap_reg);
        endfunction

        function void set_capacity(logic [CAP_W-1:0] value);
            cap_reg = value;
        endfunction

        function void drop_at(int p);
            for (int i = p; i + 1 < held; i++) begin
                tags[i] = tags[i + 1];
                stamps[i] = stamps[i + 1];
            end
            held--;
        endfunction

        function void note_command(logic [2:0] cmd, logic [TAG_W-1:0] tag,
                                   logic [STAMP_W-1:0] stamp, logic [3:0] pos);
            t_queue_result r;
            r = '0;
            case (cmd)
                CMD_PUSH: begin
                    if (held < capacity() && held < DEPTH) begin
                        tags[held] = tag;
                        stamps[held] = stamp;
                        held++;
                        r.ok = 1'b1;
                    end
                end
                CMD_POP: begin
                    if (held > 0) begin
                        r.tag = tags[0];
                        r.stamp = stamps[0];
                        drop_at(0);
                        r.ok = 1'b1;
                    end
                end
                CMD_SEARCH: begin
                    for (int i = 0; i < held; i++) begin
                        if (tags[i] == tag) begin
                            r.found = i[3:0];
                            r.ok = 1'b1;
                            break;
                        end
                    end
                end
                CMD_REMOVE: begin
                    if (int'(pos) < held) begin
                        r.tag = tags[pos];
                        r.stamp = stamps[pos];
                        drop_at(int'(pos));
                        r.ok = 1'b1;
                    end
                end
                CMD_READ: begin
                    if (int'(pos) < held) begin
                        r.stamp = stamps[pos];
                        r.ok = 1'b1;
                    end
                end
                default: begin
                end
            endcase
            r.count = held[4:0];
            r.empty = (held == 0);
            r.full = (held >= capacity());
            r.head = (held > 0) ? stamps[0] : '0;
            awaited.push_back(r);
        endfunction

        function void compare_field(string name, logic [63:0] want, logic [63:0] got);
            if (want !== got) begin
                errors++;
                $display("%0t: %s mismatch, expected %h, got %h", $time, name, want, got);
            end
        endfunction

        function void check_outcome(t_queue_result got);
            t_queue_result want;
            if (awaited.size() == 0) begin
                errors++;
                $display("%0t: result with no item outstanding", $time);
                return;
            end
            want = awaited.pop_front();
            compare_field("done_ok", 64'(want.ok), 64'(got.ok));
            compare_field("tag_out", 64'(want.tag), 64'(got.tag));
            compare_field("stamp_out", 64'(want.stamp), 64'(got.stamp));
            compare_field("found_position", 64'(want.found), 64'(got.found));
            compare_field("entry_count", 64'(want.count), 64'(got.count));
            compare_field("is_empty", 64'(want.empty), 64'(got.empty));
            compare_field("is_full", 64'(want.full), 64'(got.full));
            compare_field("head_stamp", 64'(want.head), 64'(got.head));
        endfunction

        function int pending();
            return awaited.size();
        endfunction
    endclass

    logic               i_clk = 1'b0;
    logic               i_rst_n = 1'b0;
    logic               start = 1'b0;
    logic               busy;
    logic [2:0]         i_command = CMD_PUSH;
    logic [TAG_W-1:0]   i_owner_tag = '0;
    logic [STAMP_W-1:0] i_arrival_stamp = '0;
    logic [3:0]         i_position = '0;
    logic               i_cfg_we = 1'b0;
    logic [CAP_W-1:0]   i_cfg_wdata = '0;
    logic               o_valid;
    logic               o_done_ok;
    logic [TAG_W-1:0]   o_tag_out;
    logic [STAMP_W-1:0] o_stamp_out;
    logic [3:0]         o_found_position;
    logic [4:0]         o_entry_count;
    logic               o_is_empty;
    logic               o_is_full;
    logic [STAMP_W-1:0] o_head_stamp;

    fifo_scoreboard board = new();
    logic [TAG_W-1:0] tag_pool[8];
    int stall_cycles = 0;

    searchable_fifo_with_removal_core dut (
        .i_clk(i_clk),
        .i_rst_n(i_rst_n),
        .start(start),
        .busy(busy),
        .i_command(i_command),
        .i_owner_tag(i_owner_tag),
        .i_arrival_stamp(i_arrival_stamp),
        .i_position(i_position),
        .i_cfg_we(i_cfg_we),
        .i_cfg_wdata(i_cfg_wdata),
        .o_valid(o_valid),
        .o_done_ok(o_done_ok),
        .o_tag_out(o_tag_out),
        .o_stamp_out(o_stamp_out),
        .o_found_position(o_found_position),
        .o_entry_count(o_entry_count),
        .o_is_empty(o_is_empty),
        .o_is_full(o_is_full),
        .o_head_stamp(o_head_stamp)
    );

    always #5 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        if (i_rst_n && o_valid === 1'b1) begin
            board.check_outcome({o_done_ok, o_tag_out, o_stamp_out, o_found_position,
                                 o_entry_count, o_is_empty, o_is_full, o_head_stamp});
        end
    end

    always @(posedge i_clk) begin
        if ((start && busy === 1'b0) || o_valid === 1'b1) begin
            stall_cycles <= 0;
        end else begin
            stall_cycles <= stall_cycles + 1;
        end
        if (stall_cycles >= STALL_LIMIT) begin
            $display("FAILURE");
            $finish;
        end
    end

    task automatic send_command(input logic [2:0] cmd, input logic [TAG_W-1:0] tag,
                                input logic [STAMP_W-1:0] stamp, input logic [3:0] pos);
        start <= 1'b1;
        i_command <= cmd;
        i_owner_tag <= tag;
        i_arrival_stamp <= stamp;
        i_position <= pos;
        do @(posedge i_clk); while (busy !== 1'b0);
        board.note_command(cmd, tag, stamp, pos);
    endtask

    task automatic pause(input int cycles);
        start <= 1'b0;
        repeat (cycles) @(posedge i_clk);
    endtask

    task automatic write_capacity(input logic [CAP_W-1:0] value);
        start <= 1'b0;
        while (board.pending() != 0) @(posedge i_clk);
        repeat (2) @(posedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_wdata <= value;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        board.set_capacity(value);
    endtask

    function automatic logic [STAMP_W-1:0] random_stamp();
        logic [63:0] wide;
        wide = {$urandom(), $urandom()};
        case ($urandom_range(0, 9))
            0: return '0;
            1: return '1;
            default: return wide[STAMP_W-1:0];
        endcase
    endfunction

    task automatic random_item(input int push_bias);
        logic [2:0]       cmd;
        logic [TAG_W-1:0] tag;
        logic [3:0]       pos;
        int               s;
        if ($urandom_range(0, 99) < push_bias) begin
            cmd = CMD_PUSH;
        end else begin
            s = $urandom_range(0, 99);
            if (s < 35) cmd = CMD_POP;
            else if (s < 60) cmd = CMD_SEARCH;
            else if (s < 80) cmd = CMD_REMOVE;
            else if (s < 95) cmd = CMD_READ;
            else cmd = 3'($urandom_range(CMD_SPARE_FIRST, CMD_SPARE_LAST));
        end
        if ($urandom_range(0, 99) < 80) tag = tag_pool[$urandom_range(0, 7)];
        else tag = $urandom();
        if (board.held > 0 && $urandom_range(0, 99) < 85) begin
            pos = 4'($urandom_range(0, board.held - 1));
        end else begin
            pos = 4'($urandom_range(0, 15));
        end
        send_command(cmd, tag, random_stamp(), pos);
    endtask

    initial begin
        logic [CAP_W-1:0] phase_caps[PHASES];
        int idle_pct;
        int waited;

        phase_caps = '{5'd16, 5'd0, 5'd1, 5'd2, 5'd31, 5'd5, 5'd17, 5'd8, 5'd15,
                       5'd16, 5'd3, 5'd16, 5'd16};
        phase_caps[11] = 5'($urandom_range(0, 31));
        tag_pool[0] = '0;
        tag_pool[1] = '1;
        for (int i = 2; i < 8; i++) tag_pool[i] = $urandom();

        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        write_capacity(5'd16);

        send_command(CMD_POP, '0, '0, 4'd0);
        send_command(CMD_SEARCH, '0, '0, 4'd0);
        send_command(CMD_REMOVE, '0, '0, 4'd0);
        send_command(CMD_READ, '0, '0, 4'd15);
        send_command(CMD_SPARE_LAST, '1, '1, 4'd15);
        send_command(CMD_PUSH, '1, '1, 4'd0);
        send_command(CMD_PUSH, '0, '0, 4'd0);
        send_command(CMD_PUSH, 32'hA5A5_5A5A, 48'h1234_5678_9ABC, 4'd0);
        send_command(CMD_PUSH, '0, 48'h5, 4'd0);
        send_command(CMD_SEARCH, '0, '0, 4'd0);
        send_command(CMD_SEARCH, '1, '0, 4'd0);
        send_command(CMD_SEARCH, 32'h1234_5678, '0, 4'd0);
        send_command(CMD_READ, '0, '0, 4'd3);
        send_command(CMD_READ, '0, '0, 4'd4);
        send_command(CMD_REMOVE, '0, '0, 4'd1);
        send_command(CMD_SEARCH, '0, '0, 4'd0);
        send_command(CMD_REMOVE, '0, '0, 4'd2);
        send_command(CMD_POP, '0, '0, 4'd0);
        write_capacity(5'd1);
        send_command(CMD_PUSH, 32'h0000_0001, 48'h1, 4'd0);
        write_capacity(5'd0);
        send_command(CMD_PUSH, 32'h0000_0002, 48'h2, 4'd0);
        send_command(CMD_POP, '0, '0, 4'd0);
        write_capacity(5'd2);
        send_command(CMD_PUSH, 32'h0000_0003, 48'h3, 4'd0);
        send_command(CMD_PUSH, 32'h0000_0004, 48'h4, 4'd0);
        send_command(CMD_PUSH, 32'h0000_0005, 48'h5, 4'd0);
        write_capacity(5'd1);
        send_command(CMD_PUSH, 32'h0000_0006, 48'h6, 4'd0);
        send_command(CMD_POP, '0, '0, 4'd0);
        send_command(CMD_POP, '0, '0, 4'd0);

        for (int ph = 0; ph < PHASES; ph++) begin
            write_capacity(phase_caps[ph]);
            case ($urandom_range(0, 2))
                0: idle_pct = 0;
                1: idle_pct = 15;
                default: idle_pct = 35;
            endcase
            if (ph == PHASES - 1) idle_pct = 0;
            for (int k = 0; k < PHASE_ITEMS; k++) begin
                random_item(((k / 20) % 2 == 0) ? 80 : 20);
                if ($urandom_range(0, 99) < idle_pct) pause($urandom_range(1, 11));
            end
        end

        start <= 1'b0;
        waited = 0;
        while (board.pending() != 0 && waited < 100) begin
            @(posedge i_clk);
            waited++;
        end
        repeat (3) @(posedge i_clk);
        if (board.pending() != 0) begin
            $display("%0t: %0d results never arrived", $time, board.pending());
        end
        if (board.errors == 0 && board.pending() == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule
